// ===== src/mpfc_pkg.sv =====
package mpfc_pkg;

	// Fixed field widths
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;
	localparam int DEPTH_W   = 6;
	localparam int OFFSET_W  = 5;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_SRC_RED   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_GREEN = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SRC_BLUE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DST_RED   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DST_GREEN = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DST_BLUE  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DST_ALPHA = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MONO      = 3'd7;

	// Reset values (RGB565 in, RGB888 out, mono on)
	localparam logic [DATA_W-1:0] RST_SRC_RED   = 32'h0000_F800;
	localparam logic [DATA_W-1:0] RST_SRC_GREEN = 32'h0000_07E0;
	localparam logic [DATA_W-1:0] RST_SRC_BLUE  = 32'h0000_001F;
	localparam logic [DATA_W-1:0] RST_DST_RED   = 32'h00FF_0000;
	localparam logic [DATA_W-1:0] RST_DST_GREEN = 32'h0000_FF00;
	localparam logic [DATA_W-1:0] RST_DST_BLUE  = 32'h0000_00FF;
	localparam logic [DATA_W-1:0] RST_DST_ALPHA = 32'h0000_0000;
	localparam logic              RST_MONO      = 1'b1;

	// Position and span of a channel mask
	typedef struct packed {
		logic [DEPTH_W-1:0]  depth;
		logic [OFFSET_W-1:0] offset;
	} chan_shape_t;

	// Everything one channel needs
	typedef struct packed {
		logic [DATA_W-1:0] src_mask;
		chan_shape_t       src;
		chan_shape_t       dst;
	} chan_cfg_t;

	typedef struct packed {
		chan_cfg_t         red;
		chan_cfg_t         green;
		chan_cfg_t         blue;
		logic [DATA_W-1:0] alpha;
		logic              mono;
	} cfg_t;

	// Offset = lowest set bit, depth = highest set bit - offset + 1; zero mask gives zeros
	function automatic chan_shape_t mask_shape(input logic [DATA_W-1:0] m);
		chan_shape_t         s;
		logic [OFFSET_W-1:0] lo_idx;
		logic [OFFSET_W-1:0] hi_idx;
		lo_idx = '0;
		hi_idx = '0;
		for (int i = DATA_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				lo_idx = OFFSET_W'(i);
			end
		end
		for (int i = 0; i < DATA_W; i++) begin
			if (m[i]) begin
				hi_idx = OFFSET_W'(i);
			end
		end
		if (m == '0) begin
			s.depth  = '0;
			s.offset = '0;
		end else begin
			s.depth  = DEPTH_W'(hi_idx) - DEPTH_W'(lo_idx) + DEPTH_W'(1);
			s.offset = lo_idx;
		end
		return s;
	endfunction

endpackage

// ===== src/mpfc_cfg.sv =====
module mpfc_cfg
	import mpfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t        cfg_q;
	chan_shape_t wr_shape;

	// Mask shape is derived once, at write time
	assign wr_shape = mask_shape(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red.src_mask   <= RST_SRC_RED;
			cfg_q.red.src        <= mask_shape(RST_SRC_RED);
			cfg_q.red.dst        <= mask_shape(RST_DST_RED);
			cfg_q.green.src_mask <= RST_SRC_GREEN;
			cfg_q.green.src      <= mask_shape(RST_SRC_GREEN);
			cfg_q.green.dst      <= mask_shape(RST_DST_GREEN);
			cfg_q.blue.src_mask  <= RST_SRC_BLUE;
			cfg_q.blue.src       <= mask_shape(RST_SRC_BLUE);
			cfg_q.blue.dst       <= mask_shape(RST_DST_BLUE);
			cfg_q.alpha          <= RST_DST_ALPHA;
			cfg_q.mono           <= RST_MONO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_RED: begin
					cfg_q.red.src_mask <= cfg_wdata;
					cfg_q.red.src      <= wr_shape;
				end
				REG_SRC_GREEN: begin
					cfg_q.green.src_mask <= cfg_wdata;
					cfg_q.green.src      <= wr_shape;
				end
				REG_SRC_BLUE: begin
					cfg_q.blue.src_mask <= cfg_wdata;
					cfg_q.blue.src      <= wr_shape;
				end
				REG_DST_RED:   cfg_q.red.dst   <= wr_shape;
				REG_DST_GREEN: cfg_q.green.dst <= wr_shape;
				REG_DST_BLUE:  cfg_q.blue.dst  <= wr_shape;
				REG_DST_ALPHA: cfg_q.alpha     <= cfg_wdata;
				REG_MONO:      cfg_q.mono      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mpfc_chan.sv =====
module mpfc_chan
	import mpfc_pkg::*;
(
	input  logic [DATA_W-1:0] px,
	input  chan_cfg_t         ccfg,
	output logic [DATA_W-1:0] value
);

	logic [DATA_W-1:0]  raw;
	logic [DEPTH_W-1:0] sd;
	logic [DEPTH_W-1:0] dd;
	logic [DEPTH_W-1:0] hi;
	logic [DEPTH_W-1:0] lo;
	logic [DEPTH_W-1:0] nar;

	// Extract the channel down to bit 0
	assign raw = (px & ccfg.src_mask) >> ccfg.src.offset;
	assign sd  = ccfg.src.depth;
	assign dd  = ccfg.dst.depth;
	assign hi  = dd - sd;
	assign lo  = (sd > hi) ? (sd - hi) : '0;
	assign nar = sd - dd;

	// Widen by replicating top bits into the gap, narrow by dropping low bits
	always_comb begin
		if (sd < dd) begin
			value = (raw << hi) | (raw >> lo);
		end else if (sd > dd) begin
			value = raw >> nar;
		end else begin
			value = raw;
		end
	end

endmodule

// ===== src/mask_pixel_format_converter_core.sv =====
// Accepted pixels pass from the input register through shift/mask logic to the output register.
// Throughput: one pixel per clock while the output is not stalled by out_ready.
// in_ready stays high while the output register is empty or being taken the same cycle.
// Reset (arst_n low, asynchronous): both pipeline stages empty, format registers return to
// RGB565 source, RGB888 destination, zero alpha, mono step on.
module mask_pixel_format_converter_core
	import mpfc_pkg::*;
#(
	parameter int PIXEL_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [DATA_W-1:0]    pixel_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    pixel_out,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [PIXEL_WIDTH-1:0] pixel_s1;
	logic                   out_valid_q;
	logic [PIXEL_WIDTH-1:0] pixel_out_q;
	logic                   advance;
	logic [DATA_W-1:0]      px;
	logic [DATA_W-1:0]      r_val;
	logic [DATA_W-1:0]      g_val;
	logic [DATA_W-1:0]      b_val;
	logic [DATA_W-1:0]      r_fin;
	logic [DATA_W-1:0]      g_fin;
	logic [DATA_W-1:0]      b_fin;
	logic [7:0]             mono_avg;
	logic [DATA_W-1:0]      result;

	mpfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake: stage 1 moves on whenever the output register is free or drained
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Input register, pixel trimmed to the word width
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_s1 <= pixel_in[PIXEL_WIDTH-1:0];
		end
	end

	assign px = DATA_W'(pixel_s1);

	// Per-channel extract and depth fit
	mpfc_chan u_red (
		.px    (px),
		.ccfg  (cfg.red),
		.value (r_val)
	);

	mpfc_chan u_green (
		.px    (px),
		.ccfg  (cfg.green),
		.value (g_val)
	);

	mpfc_chan u_blue (
		.px    (px),
		.ccfg  (cfg.blue),
		.value (b_val)
	);

	// Mono: low bytes of all channels become the red/blue average
	assign mono_avg = 8'(({1'b0, r_val[7:0]} + {1'b0, b_val[7:0]}) >> 1);

	always_comb begin
		if (cfg.mono) begin
			r_fin = {r_val[DATA_W-1:8], mono_avg};
			g_fin = {g_val[DATA_W-1:8], mono_avg};
			b_fin = {b_val[DATA_W-1:8], mono_avg};
		end else begin
			r_fin = r_val;
			g_fin = g_val;
			b_fin = b_val;
		end
	end

	// Pack into destination word over the alpha bits
	assign result = cfg.alpha
		| (r_fin << cfg.red.dst.offset)
		| (g_fin << cfg.green.dst.offset)
		| (b_fin << cfg.blue.dst.offset);

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pixel_out_q <= result[PIXEL_WIDTH-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = DATA_W'(pixel_out_q);

	// A transaction in stage 1 that moves on must show up at the output
	a_stage_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("stage 1 transaction lost");

	// Output never becomes valid without a transaction in stage 1 the cycle before
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("output valid without source transaction");

	// Back-pressure only when both stages are full and the output is stalled
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled with room in pipeline");

endmodule

// ===== sim/pixel_convert_checker.sv =====
`timescale 1ns / 100ps

// Watches both pixel channels and the register port, predicts every converted
// pixel from its own copy of the format registers, and compares in order.
module pixel_convert_checker
	import mpfc_pkg::*;
#(
	parameter int PIXEL_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [DATA_W-1:0]    pixel_in,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [DATA_W-1:0]    pixel_out,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata,
	output int                   mismatch_count,
	output int                   outstanding
);

	localparam logic [63:0] LOW32 = 64'hFFFF_FFFF;
	localparam logic [63:0] PIX_MASK = (PIXEL_WIDTH >= 32) ? LOW32 :
		((64'd1 << PIXEL_WIDTH) - 64'd1);

	// Shadow copy of the format registers; channel order red, green, blue
	logic [DATA_W-1:0] src_mask [3];
	logic [DATA_W-1:0] dst_mask [3];
	logic [DATA_W-1:0] alpha_bits;
	logic              mono_on;

	logic [DATA_W-1:0] expected_pixels [$];

	// Lowest set bit and span up to the highest set bit; zero mask gives zeros
	function automatic void mask_span(input logic [DATA_W-1:0] m, output int span,
		output int lsb);
		lsb  = 0;
		span = 0;
		if (m != '0) begin
			for (int i = DATA_W - 1; i >= 0; i--) begin
				if (m[i]) lsb = i;
			end
			for (int i = 0; i < DATA_W; i++) begin
				if (m[i]) span = i - lsb + 1;
			end
		end
	endfunction

	// Bring a channel value from one bit depth to another
	function automatic logic [63:0] rescale(input logic [63:0] v, input int src_span,
		input int dst_span);
		int          up;
		int          down;
		logic [63:0] r;
		r = v;
		if (src_span < dst_span) begin
			up   = dst_span - src_span;
			down = (src_span > up) ? src_span - up : 0;
			r    = ((v << up) | (v >> down)) & LOW32;
		end else if (src_span > dst_span) begin
			r = v >> (src_span - dst_span);
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] convert_pixel(input logic [DATA_W-1:0] raw);
		logic [63:0] px;
		logic [63:0] chan_val [3];
		int          dst_lsb [3];
		int          s_span;
		int          s_lsb;
		int          d_span;
		logic [63:0] avg;
		logic [63:0] word;
		px = {32'd0, raw} & PIX_MASK;
		for (int c = 0; c < 3; c++) begin
			mask_span(src_mask[c], s_span, s_lsb);
			mask_span(dst_mask[c], d_span, dst_lsb[c]);
			chan_val[c] = rescale((px & {32'd0, src_mask[c]}) >> s_lsb, s_span, d_span);
		end
		// mono: low byte of every channel becomes the red/blue average
		if (mono_on) begin
			avg = ({56'd0, chan_val[0][7:0]} + {56'd0, chan_val[2][7:0]}) >> 1;
			for (int c = 0; c < 3; c++) begin
				chan_val[c] = {chan_val[c][63:8], avg[7:0]};
			end
		end
		word = {32'd0, alpha_bits};
		for (int c = 0; c < 3; c++) begin
			word = word | ((chan_val[c] << dst_lsb[c]) & LOW32);
		end
		word = word & PIX_MASK;
		return word[DATA_W-1:0];
	endfunction

	// Compare results, queue predictions, track register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mask[0] = RST_SRC_RED;
			src_mask[1] = RST_SRC_GREEN;
			src_mask[2] = RST_SRC_BLUE;
			dst_mask[0] = RST_DST_RED;
			dst_mask[1] = RST_DST_GREEN;
			dst_mask[2] = RST_DST_BLUE;
			alpha_bits  = RST_DST_ALPHA;
			mono_on     = RST_MONO;
			expected_pixels.delete();
			mismatch_count <= 0;
			outstanding    <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("pixel_out: transaction with nothing expected, actual %08h",
						pixel_out);
					mismatch_count <= mismatch_count + 1;
				end else if (expected_pixels[0] !== pixel_out) begin
					$error("pixel_out mismatch: expected %08h, actual %08h",
						expected_pixels[0], pixel_out);
					mismatch_count <= mismatch_count + 1;
					void'(expected_pixels.pop_front());
				end else begin
					void'(expected_pixels.pop_front());
				end
			end
			if (in_valid && in_ready) begin
				expected_pixels.push_back(convert_pixel(pixel_in));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_RED:   src_mask[0] = cfg_wdata;
					REG_SRC_GREEN: src_mask[1] = cfg_wdata;
					REG_SRC_BLUE:  src_mask[2] = cfg_wdata;
					REG_DST_RED:   dst_mask[0] = cfg_wdata;
					REG_DST_GREEN: dst_mask[1] = cfg_wdata;
					REG_DST_BLUE:  dst_mask[2] = cfg_wdata;
					REG_DST_ALPHA: alpha_bits  = cfg_wdata;
					REG_MONO:      mono_on     = cfg_wdata[0];
					default: ;
				endcase
			end
			outstanding <= expected_pixels.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import mpfc_pkg::*;

	localparam int PIX_W = 32;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [DATA_W-1:0]    pixel_in  = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    pixel_out;
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_SRC_RED;
	logic [DATA_W-1:0]    cfg_wdata = '0;

	int mismatch_count;
	int outstanding;

	// Idle control: percent chance of a burst per transaction; calm turns idling off
	int tx_gap_pct   = 20;
	int rx_stall_pct = 20;
	bit calm         = 1'b0;

	logic [DATA_W-1:0] corner_pixels [10] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0000_F800, 32'h0000_07E0,
		32'h0000_001F, 32'h0001_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000
	};

	mask_pixel_format_converter_core #(
		.PIXEL_WIDTH(PIX_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	pixel_convert_checker #(
		.PIXEL_WIDTH(PIX_W)
	) conv_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_in       (pixel_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pixel_out      (pixel_out),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stall bursts with out_ready held low
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (calm || $urandom_range(0, 99) >= rx_stall_pct) begin
				out_ready = 1'b1;
			end else begin
				out_ready = 1'b0;
				hold = $urandom_range(1, 13);
				repeat (hold - 1) @(negedge clk);
			end
		end
	end

	// Offer one pixel, optionally after an idle burst, and wait for the transaction
	task automatic push_pixel(input logic [DATA_W-1:0] px);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < tx_gap_pct) gap = $urandom_range(1, 13);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			pixel_in = $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		pixel_in = px;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every predicted pixel has come out
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Write the whole register set; mono write carries random upper bits
	task automatic load_format(input logic [DATA_W-1:0] sr, sg, sb, dr, dg, db, alpha,
		input logic mono);
		logic [DATA_W-1:0] mono_word;
		mono_word    = $urandom;
		mono_word[0] = mono;
		write_reg(REG_SRC_RED, sr);
		write_reg(REG_SRC_GREEN, sg);
		write_reg(REG_SRC_BLUE, sb);
		write_reg(REG_DST_RED, dr);
		write_reg(REG_DST_GREEN, dg);
		write_reg(REG_DST_BLUE, db);
		write_reg(REG_DST_ALPHA, alpha);
		write_reg(REG_MONO, mono_word);
	endtask

	// Common packed layouts: 565, 555, 444, 888, BGR 888
	task automatic pick_format(input int sel, output logic [DATA_W-1:0] r, g, b);
		case (sel)
			0:       begin r = 32'h0000_F800; g = 32'h0000_07E0; b = 32'h0000_001F; end
			1:       begin r = 32'h0000_7C00; g = 32'h0000_03E0; b = 32'h0000_001F; end
			2:       begin r = 32'h0000_0F00; g = 32'h0000_00F0; b = 32'h0000_000F; end
			3:       begin r = 32'h00FF_0000; g = 32'h0000_FF00; b = 32'h0000_00FF; end
			default: begin r = 32'h0000_00FF; g = 32'h0000_FF00; b = 32'h00FF_0000; end
		endcase
	endtask

	function automatic logic [DATA_W-1:0] random_mask();
		int          span;
		int          lsb;
		logic [63:0] m;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: begin
				span = $urandom_range(1, 32);
				lsb  = $urandom_range(0, 32 - span);
				m    = ((64'd1 << span) - 64'd1) << lsb;
				return m[DATA_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom & 32'h0000_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_setup();
		logic [DATA_W-1:0] m [6];
		logic [DATA_W-1:0] alpha;
		if ($urandom_range(0, 3) == 0) begin
			pick_format($urandom_range(0, 4), m[0], m[1], m[2]);
			pick_format($urandom_range(0, 4), m[3], m[4], m[5]);
		end else begin
			for (int i = 0; i < 6; i++) m[i] = random_mask();
		end
		case ($urandom_range(0, 3))
			0:       alpha = '0;
			1:       alpha = '1;
			2:       alpha = 32'hFF00_0000;
			default: alpha = $urandom;
		endcase
		load_format(m[0], m[1], m[2], m[3], m[4], m[5], alpha, 1'($urandom_range(0, 1)));
	endtask

	// Stimulus and verdict
	initial begin
		int idle_choice [4];
		idle_choice = '{0, 10, 30, 60};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset formats (565 to 888, mono on)
		foreach (corner_pixels[i]) push_pixel(corner_pixels[i]);
		settle();

		// Mono off through a write with upper bits set
		write_reg(REG_MONO, 32'hFFFF_FFFE);
		push_pixel(32'h0000_F800);
		push_pixel(32'h0000_07E0);
		push_pixel(32'h0000_FFFF);
		settle();

		// All masks zero, alpha all ones
		load_format('0, '0, '0, '0, '0, '0, '1, 1'b1);
		push_pixel(32'hFFFF_FFFF);
		push_pixel(32'h1234_5678);
		settle();

		// Full-width masks everywhere
		load_format('1, '1, '1, '1, '1, '1, '0, 1'b0);
		push_pixel(32'hFFFF_FFFF);
		push_pixel(32'h8000_0001);
		push_pixel(32'h0000_0000);
		settle();

		// Widening one bit to 32 and to 2, narrowing 8 to 4
		load_format(32'h0000_0001, 32'h8000_0000, 32'h0000_FF00,
			'1, 32'h0000_0300, 32'hF000_0000, 32'h0000_00F0, 1'b0);
		push_pixel(32'h8000_0001);
		push_pixel(32'h0000_A501);
		push_pixel(32'h7FFF_FFFE);
		settle();

		// Narrowing 32 to 1 and 16 to 1, mono on
		load_format('1, 32'h0000_0000, 32'h00FF_FF00,
			32'h8000_0000, 32'h0000_FF00, 32'h0000_0001, 32'h0000_0000, 1'b1);
		push_pixel(32'hFFFF_FFFF);
		push_pixel(32'h8000_0000);
		push_pixel(32'h0080_0000);
		settle();

		// Random formats with random idling
		for (int phase = 0; phase < 11; phase++) begin
			tx_gap_pct   = idle_choice[$urandom_range(0, 3)];
			rx_stall_pct = idle_choice[$urandom_range(0, 3)];
			random_setup();
			repeat (100) push_pixel(random_pixel());
			settle();
		end

		// Last stretch with no idling on either side
		calm = 1'b1;
		random_setup();
		repeat (100) push_pixel(random_pixel());
		settle();
		repeat (8) @(negedge clk);

		if (mismatch_count == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== mask_pixel_format_converter_core.f =====
src/mpfc_pkg.sv
src/mpfc_cfg.sv
src/mpfc_chan.sv
src/mask_pixel_format_converter_core.sv
sim/pixel_convert_checker.sv
sim/tb.sv
